[hw/rtl/rtt_pkg.sv]
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, widths and elaboration-time trig helpers for the ring
// triangle tessellator.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // Default number of angular segments per ring
  localparam int unsigned SEGMENTS_DEF = 32;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned RAD_W   = 23;
  localparam int unsigned RGBA_W  = 32;
  // Signed radius after adding or removing half the thickness
  localparam int unsigned SRAD_W  = 25;
  // Signed Q1.15 trig value, 32768 stands for 1.0
  localparam int unsigned TRIG_W  = 17;
  localparam int unsigned PROD_W  = SRAD_W + TRIG_W;
  localparam int unsigned QUOT_W  = PROD_W - 15;
  localparam int unsigned SUM_W   = QUOT_W + 1;

  // Quarter turn in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(8388608);

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [RAD_W-1:0]   ring_radius;
    logic        [RAD_W-1:0]   ring_width;
    logic        [RGBA_W-1:0]  rgba;
  } rtt_ring_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [RGBA_W-1:0]  tri_rgba;
    logic                      last_triangle;
  } rtt_tri_t;

  // Ring descriptor held in the queue between front and back
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [SRAD_W-1:0]  r_inner;
    logic signed [SRAD_W-1:0]  r_outer;
    logic        [RGBA_W-1:0]  rgba;
  } rtt_desc_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } rtt_trig_t;

  // Q2.30 to Q1.15 magnitude, round half up, clamp to 0..1.0
  function automatic logic signed [TRIG_W-1:0] q30_to_q15(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = 64'sd0;
    if (v > 64'sd0) begin
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32768) begin
        r = 64'sd32768;
      end
    end
    return TRIG_W'(r);
  endfunction

  // Cos and sin of quadrant plus offset t (Q2.30) by a series with eight terms past the first
  function automatic rtt_trig_t trig_of(input logic [63:0] t, input logic [1:0] quad);
    logic [63:0]        t2;
    logic [63:0]        st;
    logic [63:0]        ct;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    logic signed [TRIG_W-1:0] cq;
    logic signed [TRIG_W-1:0] sq;
    rtt_trig_t          r;
    t2 = (t * t) >> 30;
    st = t;
    ct = 64'd1 << 30;
    ss = $signed(t);
    cs = $signed(64'd1 << 30);
    for (int n = 1; n <= 8; n++) begin
      st = ((st * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
      ct = ((ct * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        ss = ss - $signed(st);
        cs = cs - $signed(ct);
      end else begin
        ss = ss + $signed(st);
        cs = cs + $signed(ct);
      end
    end
    cq = q30_to_q15(cs);
    sq = q30_to_q15(ss);
    case (quad)
      2'd0: begin
        r.cos_v = cq;
        r.sin_v = sq;
      end
      2'd1: begin
        r.cos_v = -sq;
        r.sin_v = cq;
      end
      2'd2: begin
        r.cos_v = -cq;
        r.sin_v = -sq;
      end
      default: begin
        r.cos_v = sq;
        r.sin_v = -cq;
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/rtt_front.sv]
// ----------------------------------------------------------------------------
// rtt_front
// Accepts ring requests, derives inner and outer radii and holds the
// descriptors in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rtt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rtt_pkg::rtt_ring_in_t in_data_i,
  output logic                 head_valid_o,
  output rtt_pkg::rtt_desc_t   head_o,
  input  logic                 pop_i
);

  rtt_pkg::rtt_desc_t entry_q [2];
  rtt_pkg::rtt_desc_t desc;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;
  logic signed [rtt_pkg::SRAD_W-1:0] rad;
  logic signed [rtt_pkg::SRAD_W-1:0] half;

  // Halve the thickness, form inner and outer radius
  always_comb begin
    rad            = $signed({2'b00, in_data_i.ring_radius});
    half           = $signed({3'b000, in_data_i.ring_width[rtt_pkg::RAD_W-1:1]});
    desc.center_x  = in_data_i.center_x;
    desc.center_y  = in_data_i.center_y;
    desc.r_inner   = rad - half;
    desc.r_outer   = rad + half;
    desc.rgba      = in_data_i.rgba;
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = entry_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the accepted word into the queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= desc;
    end
  end

endmodule

[hw/rtl/rtt_back.sv]
// ----------------------------------------------------------------------------
// rtt_back
// Walks the triangles of the ring at the queue head, one per cycle while the output is not stalled, and
// places the three vertices through a four-stage multiply pipeline.
// ----------------------------------------------------------------------------
module rtt_back #(
  parameter int unsigned SEGMENTS = rtt_pkg::SEGMENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  rtt_pkg::rtt_desc_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtt_pkg::rtt_tri_t  out_data_o
);

  localparam int unsigned TRIS = 2 * SEGMENTS;
  localparam int unsigned IW   = $clog2(TRIS);
  localparam int unsigned KW   = IW - 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TRIS - 1);
  localparam logic [KW-1:0] LAST_K   = KW'(SEGMENTS - 1);

  localparam int unsigned SW = rtt_pkg::SRAD_W;
  localparam int unsigned TW = rtt_pkg::TRIG_W;
  localparam int unsigned PW = rtt_pkg::PROD_W;
  localparam int unsigned QW = rtt_pkg::QUOT_W;
  localparam int unsigned UW = rtt_pkg::SUM_W;
  localparam int unsigned CW = rtt_pkg::COORD_W;

  // Constant cos/sin table, one entry per step of the turn
  rtt_pkg::rtt_trig_t trig_tab [SEGMENTS];

  for (genvar j = 0; j < SEGMENTS; j++) begin : g_tab
    localparam int unsigned FOUR = 4 * j;
    localparam int unsigned QUAD = (FOUR / SEGMENTS) % 4;
    localparam int unsigned REM  = FOUR % SEGMENTS;
    localparam logic [63:0] T_Q30 =
      (64'(REM) * rtt_pkg::HALF_PI_Q30 + 64'(SEGMENTS / 2)) / 64'(SEGMENTS);
    localparam rtt_pkg::rtt_trig_t ENTRY = rtt_pkg::trig_of(T_Q30, 2'(QUAD));
    assign trig_tab[j] = ENTRY;
  end

  logic adv;
  logic [IW-1:0] idx_q, idx_d;
  logic [KW-1:0] k_start;
  logic [KW-1:0] k_end;
  logic          odd;
  rtt_pkg::rtt_trig_t t_start;
  rtt_pkg::rtt_trig_t t_end;

  // Stage 1: operands per vertex lane
  logic                    s1_valid_q;
  logic signed [SW-1:0]    s1_rad_q [3];
  rtt_pkg::rtt_trig_t      s1_trig_q [3];
  logic signed [SW-1:0]    rad_sel [3];
  rtt_pkg::rtt_trig_t      trig_sel [3];
  // Stage 2: products
  logic                    s2_valid_q;
  logic signed [PW-1:0]    s2_px_q [3];
  logic signed [PW-1:0]    s2_py_q [3];
  // Stage 3: rounded offsets
  logic                    s3_valid_q;
  logic signed [QW-1:0]    s3_qx_q [3];
  logic signed [QW-1:0]    s3_qy_q [3];
  // Stage 4: output word
  logic                    s4_valid_q;
  logic signed [CW-1:0]    s4_x_q [3];
  logic signed [CW-1:0]    s4_y_q [3];

  logic signed [CW-1:0]    s1_cx_q, s2_cx_q, s3_cx_q;
  logic signed [CW-1:0]    s1_cy_q, s2_cy_q, s3_cy_q;
  logic [rtt_pkg::RGBA_W-1:0] s1_rgba_q, s2_rgba_q, s3_rgba_q, s4_rgba_q;
  logic                    s1_last_q, s2_last_q, s3_last_q, s4_last_q;

  // Hold the whole pipeline while a finished word waits
  assign adv = !s4_valid_q || !out_stall_i;

  assign odd     = idx_q[0];
  assign k_start = idx_q[IW-1:1];
  assign k_end   = (k_start == LAST_K) ? '0 : k_start + KW'(1);
  assign t_start = trig_tab[k_start];
  assign t_end   = trig_tab[k_end];
  assign pop_o   = adv && head_valid_i && (idx_q == LAST_IDX);

  // Pick radius and angle for each vertex of this triangle
  always_comb begin
    rad_sel[0]  = head_i.r_inner;
    trig_sel[0] = t_end;
    rad_sel[1]  = odd ? head_i.r_outer : head_i.r_inner;
    trig_sel[1] = t_start;
    rad_sel[2]  = head_i.r_outer;
    trig_sel[2] = odd ? t_end : t_start;
  end

  // Advance the triangle counter, wrap at the end of the ring
  always_comb begin
    idx_d = idx_q;
    if (adv && head_valid_i) begin
      idx_d = (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (adv) begin
        s1_valid_q <= head_valid_i;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cx_q   <= head_i.center_x;
      s1_cy_q   <= head_i.center_y;
      s1_rgba_q <= head_i.rgba;
      s1_last_q <= (idx_q == LAST_IDX);
      s2_cx_q   <= s1_cx_q;
      s2_cy_q   <= s1_cy_q;
      s2_rgba_q <= s1_rgba_q;
      s2_last_q <= s1_last_q;
      s3_cx_q   <= s2_cx_q;
      s3_cy_q   <= s2_cy_q;
      s3_rgba_q <= s2_rgba_q;
      s3_last_q <= s2_last_q;
      s4_rgba_q <= s3_rgba_q;
      s4_last_q <= s3_last_q;
    end
  end

  for (genvar v = 0; v < 3; v++) begin : g_lane
    logic signed [PW-1:0] rx;
    logic signed [PW-1:0] ry;
    logic signed [UW-1:0] sx;
    logic signed [UW-1:0] sy;

    // Round half up, then add center and saturate
    always_comb begin
      rx = s2_px_q[v] + PW'(16384);
      ry = s2_py_q[v] + PW'(16384);
      sx = UW'(s3_cx_q) + UW'(s3_qx_q[v]);
      sy = UW'(s3_cy_q) + UW'(s3_qy_q[v]);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s1_rad_q[v]  <= rad_sel[v];
        s1_trig_q[v] <= trig_sel[v];
        s2_px_q[v]   <= PW'(s1_rad_q[v]) * PW'(s1_trig_q[v].cos_v);
        s2_py_q[v]   <= PW'(s1_rad_q[v]) * PW'(s1_trig_q[v].sin_v);
        s3_qx_q[v]   <= QW'(rx >>> 15);
        s3_qy_q[v]   <= QW'(ry >>> 15);
        if (sx > rtt_pkg::COORD_MAX) begin
          s4_x_q[v] <= CW'(rtt_pkg::COORD_MAX);
        end else if (sx < rtt_pkg::COORD_MIN) begin
          s4_x_q[v] <= CW'(rtt_pkg::COORD_MIN);
        end else begin
          s4_x_q[v] <= CW'(sx);
        end
        if (sy > rtt_pkg::COORD_MAX) begin
          s4_y_q[v] <= CW'(rtt_pkg::COORD_MAX);
        end else if (sy < rtt_pkg::COORD_MIN) begin
          s4_y_q[v] <= CW'(rtt_pkg::COORD_MIN);
        end else begin
          s4_y_q[v] <= CW'(sy);
        end
      end
    end
  end

  // Drive the result word
  always_comb begin
    out_valid_o              = s4_valid_q;
    out_data_o.ax            = s4_x_q[0];
    out_data_o.ay            = s4_y_q[0];
    out_data_o.bx            = s4_x_q[1];
    out_data_o.by_coord      = s4_y_q[1];
    out_data_o.cx            = s4_x_q[2];
    out_data_o.cy            = s4_y_q[2];
    out_data_o.tri_rgba      = s4_rgba_q;
    out_data_o.last_triangle = s4_last_q;
  end

endmodule

[hw/rtl/ring_triangle_tessellator.sv]
// Path: an accepted ring is written to a queue entry, and its first triangle word then passes stages s1 to s4.
// Throughput: 2*SEGMENTS triangles per ring (64 at the default), one triangle per
// cycle unless the output stalls, as set by the back-end triangle sequencer.
// A two-entry descriptor queue lets new rings enter while a ring is emitted.
// Reset clears the queue count, the triangle counter and the stage valids;
// there is no clearing pass.
// ----------------------------------------------------------------------------
// ring_triangle_tessellator
// Cuts a ring request into a run of triangles covering the annulus.
// ----------------------------------------------------------------------------
module ring_triangle_tessellator #(
  parameter int unsigned SEGMENTS = rtt_pkg::SEGMENTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtt_pkg::rtt_ring_in_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rtt_pkg::rtt_tri_t     out_data_o
);

  logic               head_valid;
  rtt_pkg::rtt_desc_t head;
  logic               pop;

  // Front: accept and queue ring descriptors
  rtt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back: emit triangles of the head ring
  rtt_back #(
    .SEGMENTS (SEGMENTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring triangle tessellator. Ring requests are
// sent over the valid/stall input channel, and each accepted word is
// tessellated in the bench into its expected triangle words. The output
// channel is stalled at random, and every triangle word is checked field by
// field against the oldest expected word. Directed rings cover the field
// extremes, saturation, odd thickness and rings thicker than twice their
// radius. Random rings then run under four idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int     SEG              = rtt_pkg::SEGMENTS_DEF;
  localparam u64_t   QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint COORD_HI         = 64'sd8388607;
  localparam longint COORD_LO         = -64'sd8388608;
  localparam longint UNIT_Q15         = 64'sd32768;
  // Longest stretch with no word moving on either channel
  localparam int     QUIET_LIMIT      = 2000;
  // Cycles to watch for stray words once nothing is pending
  localparam int     DRAIN_CYCLES     = 20;
  localparam int     LOG_CAP          = 50;
  localparam int     RANDOM_PER_PHASE = 89;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  rtt_pkg::rtt_ring_in_t in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rtt_pkg::rtt_tri_t     out_data;

  int                    sender_idle_pct = 0;
  int                    stall_pct       = 0;
  int                    mismatch_count  = 0;
  int                    tri_count       = 0;
  int                    quiet_cycles    = 0;
  rtt_pkg::rtt_tri_t     pending_triangles[$];
  rtt_pkg::rtt_tri_t     want_tri;

  ring_triangle_tessellator #(
    .SEGMENTS(SEG)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q2.30 magnitude to Q1.15, round half up, clamp to 0..1.0
  function automatic longint round_q30(input longint v);
    longint r;
    if (v <= 0) begin
      return 0;
    end
    r = (v + 64'sd16384) / 64'sd32768;
    if (r > UNIT_Q15) begin
      r = UNIT_Q15;
    end
    return r;
  endfunction

  // Cos and sin of step/SEG of a full turn, folded to a quadrant offset
  function automatic void step_trig(input int step, output longint c, output longint s);
    int unsigned four;
    int unsigned quad;
    int unsigned rem;
    u64_t        t;
    u64_t        t2;
    u64_t        st;
    u64_t        ct;
    longint      ss;
    longint      cs;
    longint      cq;
    longint      sq;
    four = step * 4;
    quad = (four / SEG) % 4;
    rem  = four % SEG;
    t    = (u64_t'(rem) * QUARTER_TURN_Q30 + u64_t'(SEG / 2)) / u64_t'(SEG);
    t2   = (t * t) >> 30;
    st   = t;
    ct   = u64_t'(1) << 30;
    ss   = longint'(st);
    cs   = longint'(ct);
    // Taylor series, eight terms past the first, truncating each term
    for (int n = 1; n <= 8; n++) begin
      st = ((st * t2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
      ct = ((ct * t2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        ss = ss - longint'(st);
        cs = cs - longint'(ct);
      end else begin
        ss = ss + longint'(st);
        cs = cs + longint'(ct);
      end
    end
    cq = round_q30(cs);
    sq = round_q30(ss);
    case (quad)
      0: begin
        c = cq;
        s = sq;
      end
      1: begin
        c = -sq;
        s = cq;
      end
      2: begin
        c = -cq;
        s = -sq;
      end
      default: begin
        c = sq;
        s = -cq;
      end
    endcase
  endfunction

  // Center plus radius times trig, rounded toward plus infinity on ties, saturated
  function automatic logic signed [rtt_pkg::COORD_W-1:0] vertex_coord(input longint ctr,
                                                                      input longint rad,
                                                                      input longint trig);
    longint v;
    v = ctr + ((rad * trig + 64'sd16384) >>> 15);
    if (v > COORD_HI) begin
      v = COORD_HI;
    end
    if (v < COORD_LO) begin
      v = COORD_LO;
    end
    return v[rtt_pkg::COORD_W-1:0];
  endfunction

  // Queue every triangle word that one accepted ring should produce
  function automatic void tessellate_ring(input rtt_pkg::rtt_ring_in_t ring);
    longint            ctr_x;
    longint            ctr_y;
    longint            rad;
    longint            half;
    longint            r_in;
    longint            r_out;
    longint            c0;
    longint            s0;
    longint            c1;
    longint            s1;
    rtt_pkg::rtt_tri_t lo_tri;
    rtt_pkg::rtt_tri_t hi_tri;
    logic signed [rtt_pkg::COORD_W-1:0] isx, isy, osx, osy, iex, iey, oex, oey;
    ctr_x = longint'($signed(ring.center_x));
    ctr_y = longint'($signed(ring.center_y));
    rad   = longint'(ring.ring_radius);
    half  = longint'(ring.ring_width >> 1);
    r_in  = rad - half;
    r_out = rad + half;
    for (int k = 0; k < SEG; k++) begin
      step_trig(k, c0, s0);
      step_trig(k + 1, c1, s1);
      isx = vertex_coord(ctr_x, r_in, c0);
      isy = vertex_coord(ctr_y, r_in, s0);
      osx = vertex_coord(ctr_x, r_out, c0);
      osy = vertex_coord(ctr_y, r_out, s0);
      iex = vertex_coord(ctr_x, r_in, c1);
      iey = vertex_coord(ctr_y, r_in, s1);
      oex = vertex_coord(ctr_x, r_out, c1);
      oey = vertex_coord(ctr_y, r_out, s1);
      lo_tri.ax            = iex;
      lo_tri.ay            = iey;
      lo_tri.bx            = isx;
      lo_tri.by_coord      = isy;
      lo_tri.cx            = osx;
      lo_tri.cy            = osy;
      lo_tri.tri_rgba      = ring.rgba;
      lo_tri.last_triangle = 1'b0;
      hi_tri.ax            = iex;
      hi_tri.ay            = iey;
      hi_tri.bx            = osx;
      hi_tri.by_coord      = osy;
      hi_tri.cx            = oex;
      hi_tri.cy            = oey;
      hi_tri.tri_rgba      = ring.rgba;
      hi_tri.last_triangle = (k == SEG - 1);
      pending_triangles.push_back(lo_tri);
      pending_triangles.push_back(hi_tri);
    end
  endfunction

  // Count every mismatch, log only the first few to keep the log short
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= LOG_CAP) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("triangle %0d %s got %0h want %0h",
                                tri_count, name, got, want));
    end
  endtask

  // Check each accepted triangle word, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_triangles.size() == 0) begin
        report_mismatch($sformatf("unexpected triangle word %0h", out_data));
      end else begin
        want_tri = pending_triangles.pop_front();
        check_field("ax", out_data.ax, want_tri.ax);
        check_field("ay", out_data.ay, want_tri.ay);
        check_field("bx", out_data.bx, want_tri.bx);
        check_field("by_coord", out_data.by_coord, want_tri.by_coord);
        check_field("cx", out_data.cx, want_tri.cx);
        check_field("cy", out_data.cy, want_tri.cy);
        check_field("tri_rgba", out_data.tri_rgba, want_tri.tri_rgba);
        check_field("last_triangle", out_data.last_triangle, want_tri.last_triangle);
      end
      tri_count++;
    end
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one ring word after a random idle gap, hold it until accepted
  task automatic send_ring(input rtt_pkg::rtt_ring_in_t ring);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= ring;
    @(posedge clk_i);
    while (in_stall) begin
      @(posedge clk_i);
    end
    tessellate_ring(ring);
  endtask

  // Drop valid, wait out every pending triangle, then keep watching for stray words
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_triangles.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic rtt_pkg::rtt_ring_in_t make_ring(input int cx, input int cy,
                                                      input int unsigned rad,
                                                      input int unsigned wid,
                                                      input logic [31:0] color);
    rtt_pkg::rtt_ring_in_t ring;
    ring.center_x    = rtt_pkg::COORD_W'(cx);
    ring.center_y    = rtt_pkg::COORD_W'(cy);
    ring.ring_radius = rtt_pkg::RAD_W'(rad);
    ring.ring_width  = rtt_pkg::RAD_W'(wid);
    ring.rgba        = color;
    return ring;
  endfunction

  // Well-formed rings, with full-range, thick and edge rings mixed in
  function automatic rtt_pkg::rtt_ring_in_t random_ring();
    rtt_pkg::rtt_ring_in_t ring;
    int unsigned           pick;
    int unsigned           rad;
    pick      = $urandom_range(99, 0);
    ring.rgba = $urandom();
    if (pick < 35) begin
      ring.center_x    = rtt_pkg::COORD_W'($urandom());
      ring.center_y    = rtt_pkg::COORD_W'($urandom());
      ring.ring_radius = rtt_pkg::RAD_W'($urandom());
      ring.ring_width  = rtt_pkg::RAD_W'($urandom());
    end else if (pick < 75) begin
      rad              = $urandom_range(1048575, 0);
      ring.center_x    = rtt_pkg::COORD_W'($urandom_range(2097151, 0) - 1048576);
      ring.center_y    = rtt_pkg::COORD_W'($urandom_range(2097151, 0) - 1048576);
      ring.ring_radius = rtt_pkg::RAD_W'(rad);
      ring.ring_width  = rtt_pkg::RAD_W'($urandom_range(2 * rad, 0));
    end else if (pick < 88) begin
      // thicker than twice the radius, inner vertices mirror through the center
      rad              = $urandom_range(262143, 0);
      ring.center_x    = rtt_pkg::COORD_W'($urandom_range(2097151, 0) - 1048576);
      ring.center_y    = rtt_pkg::COORD_W'($urandom_range(2097151, 0) - 1048576);
      ring.ring_radius = rtt_pkg::RAD_W'(rad);
      ring.ring_width  = rtt_pkg::RAD_W'($urandom_range(8388607, 2 * rad + 1));
    end else begin
      // center near a bound so some vertices saturate
      rad              = $urandom_range(131071, 0);
      ring.center_x    = $urandom_range(1, 0) ?
                         rtt_pkg::COORD_W'(8388607 - $urandom_range(65535, 0)) :
                         rtt_pkg::COORD_W'(-8388608 + $urandom_range(65535, 0));
      ring.center_y    = $urandom_range(1, 0) ?
                         rtt_pkg::COORD_W'(8388607 - $urandom_range(65535, 0)) :
                         rtt_pkg::COORD_W'(-8388608 + $urandom_range(65535, 0));
      ring.ring_radius = rtt_pkg::RAD_W'(rad);
      ring.ring_width  = rtt_pkg::RAD_W'($urandom_range(2 * rad, 0));
    end
    return ring;
  endfunction

  task automatic test_zero_ring();
    send_ring(make_ring(0, 0, 0, 0, 32'h0000_0000));
    send_ring(make_ring(0, 0, 256, 0, 32'hFFFF_FFFF));
  endtask

  task automatic test_odd_width_rounding();
    send_ring(make_ring(0, 0, 1, 3, 32'h0102_0304));
    send_ring(make_ring(1000, -1000, 1000, 1, 32'h1122_3344));
    send_ring(make_ring(-1, 1, 3, 5, 32'h5566_7788));
    send_ring(make_ring(12345, -54321, 25600, 2561, 32'h99AA_BBCC));
  endtask

  task automatic test_saturation();
    send_ring(make_ring(8388607, 8388607, 8388607, 0, 32'hDEAD_BEEF));
    send_ring(make_ring(-8388608, -8388608, 8388607, 8388607, 32'hFFFF_FFFF));
    send_ring(make_ring(8388607, -8388608, 0, 0, 32'h0000_0001));
    send_ring(make_ring(0, 0, 8388607, 8388607, 32'h8000_0000));
    send_ring(make_ring(-8388608, 8388607, 4194304, 2, 32'h7FFF_FFFF));
    send_ring(make_ring(8388607, 0, 8388607, 8388606, 32'hC0FF_EE00));
  endtask

  task automatic test_thick_ring();
    send_ring(make_ring(0, 0, 5000, 10000, 32'h0F0F_0F0F));
    send_ring(make_ring(0, 0, 5000, 10001, 32'hF0F0_F0F0));
    send_ring(make_ring(100, -100, 100, 8388607, 32'h1234_5678));
    send_ring(make_ring(0, 0, 0, 8388607, 32'h8765_4321));
    send_ring(make_ring(-4000000, 4000000, 2048, 3000000, 32'h3C3C_3C3C));
  endtask

  task automatic test_color_passthrough();
    send_ring(make_ring(256, 512, 25600, 512, 32'hA5A5_A5A5));
    send_ring(make_ring(-256, -512, 25600, 512, 32'h5A5A_5A5A));
    send_ring(make_ring(0, 0, 12800, 256, 32'h8000_0001));
  endtask

  task automatic test_random_rings(input int count);
    for (int i = 0; i < count; i++) begin
      send_ring(random_ring());
    end
    wait_drained();
  endtask

  initial begin
    // hold reset, then release it once
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_ring();
    test_odd_width_rounding();
    test_saturation();
    test_thick_ring();
    test_color_passthrough();
    wait_drained();

    // no idling
    sender_idle_pct = 0;
    stall_pct       = 0;
    test_random_rings(RANDOM_PER_PHASE);

    // sender idles
    sender_idle_pct = 54;
    stall_pct       = 0;
    test_random_rings(RANDOM_PER_PHASE);

    // receiver stalls
    sender_idle_pct = 0;
    stall_pct       = 54;
    test_random_rings(RANDOM_PER_PHASE);

    // both sides idle
    sender_idle_pct = 37;
    stall_pct       = 37;
    test_random_rings(RANDOM_PER_PHASE);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
